[sv/slbm_pkg.sv]
package slbm_pkg;

	// default work ram depth in bytes
	localparam int WORK_RAM_BYTES_DEF = 8192;

	// bus access kinds carried on the input tuser
	typedef enum logic [1:0] {
		KIND_CPU_RD = 2'd0,
		KIND_CPU_WR = 2'd1,
		KIND_PPU_RD = 2'd2,
		KIND_PPU_WR = 2'd3
	} kind_t;

	// register chosen by address bits 14:13 on the fifth loader write
	typedef enum logic [1:0] {
		TGT_CONTROL  = 2'd0,
		TGT_CHR_LOW  = 2'd1,
		TGT_CHR_HIGH = 2'd2,
		TGT_PRG      = 2'd3
	} tgt_t;

	// configuration register indexes
	localparam logic CFG_PRG_COUNT = 1'b0;
	localparam logic CFG_CHR_COUNT = 1'b1;

	// program banking modes held in control bits 3:2
	localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

	// reset values
	localparam logic [4:0] CONTROL_RESET   = 5'h1C;
	localparam logic [4:0] CONTROL_PRG_FIX = 5'h0C;
	localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
	localparam logic [3:0] PRG_HIGH_RESET  = 4'(PRG_COUNT_RESET - 5'd1);
	localparam logic [2:0] LOADER_LAST     = 3'd4;

	// per-transaction result carried down the pipeline
	typedef struct packed {
		logic        handled;
		logic        to_work_ram;
		logic [17:0] rom_offset;
		logic [2:0]  mirror_mode;
		logic        take_ram;
	} res_t;

endpackage

[sv/serial_loaded_bank_mapper.sv]
// Serial-loaded bank mapper: one bus access per input transaction, one result per access, in
// order. A new access is taken every cycle while the pipeline is not stalled and no clear runs;
// the work ram read and the decoded result are registered in the first stage when an access
// is taken and move into the output register when it is free, and a full output register
// with a stalled consumer still lets one more access in. Register writes from the cpu side
// take effect for the very next access. After reset the work ram is cleared one byte a cycle
// while no access is taken; configuration writes are accepted during that pass.
module serial_loaded_bank_mapper
	import slbm_pkg::*;
#(
	parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	// access stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // addr[15:0], data_in[23:16]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // rom_offset[17:0], read_data[25:18], mirror_mode[28:26]
	output logic [1:0]  m_tuser   // handled[0], to_work_ram[1]
);

	localparam int AW = $clog2(WORK_RAM_BYTES);
	localparam logic [AW-1:0] RAM_LAST = AW'(WORK_RAM_BYTES - 1);

	// work ram index: (addr & 0x1fff) mod depth, quotient stays below eight
	function automatic logic [AW-1:0] ram_index(input logic [12:0] a);
		logic [15:0] r;
		r = {3'b000, a};
		for (int i = 2; i >= 0; i--) begin
			if (r >= 16'(WORK_RAM_BYTES << i))
				r = r - 16'(WORK_RAM_BYTES << i);
		end
		return r[AW-1:0];
	endfunction

	// configuration
	logic [4:0] prg_count_q;
	logic [5:0] chr_count_q;

	// mapper registers
	logic [4:0] shift_q, shift_d;
	logic [2:0] count_q, count_d;
	logic [4:0] control_q, control_d;
	logic [4:0] chr_low_q, chr_low_d;
	logic [4:0] chr_high_q, chr_high_d;
	logic [3:0] chr_whole_q, chr_whole_d;
	logic [2:0] prg_whole_q, prg_whole_d;
	logic [3:0] prg_low_q, prg_low_d;
	logic [3:0] prg_high_q, prg_high_d;
	logic [2:0] mirror_q, mirror_d;

	// pipeline
	logic    v_s1;
	res_t    res_s1;
	res_t    res_c;
	logic    out_v_q;
	res_t    out_q;
	logic [7:0] out_rd_q;
	logic    adv;
	logic    in_acc;

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	// work ram
	logic [7:0]    mem [WORK_RAM_BYTES];
	logic [7:0]    ram_rd_q;
	logic          ram_we;
	logic [AW-1:0] ram_wa;
	logic [7:0]    ram_wd;

	// input fields
	kind_t      kind;
	logic [15:0] addr;
	logic [7:0]  din;
	logic [AW-1:0] idx;
	logic        wram_hit;
	logic        chr_ram;
	logic [4:0]  load_v;

	assign kind     = kind_t'(s_tuser);
	assign addr     = s_tdata[15:0];
	assign din      = s_tdata[23:16];
	assign idx      = ram_index(addr[12:0]);
	assign wram_hit = (addr[15:13] == 3'b011);
	assign chr_ram  = (chr_count_q == 6'd0);
	assign load_v   = {din[0], shift_q[4:1]};

	// handshake
	assign adv      = !out_v_q || m_tready;
	assign s_tready = !clr_busy_q && (!v_s1 || adv);
	assign in_acc   = s_tvalid && s_tready;

	// decode the access and work out the next register state
	always_comb begin
		res_c       = '0;
		shift_d     = shift_q;
		count_d     = count_q;
		control_d   = control_q;
		chr_low_d   = chr_low_q;
		chr_high_d  = chr_high_q;
		chr_whole_d = chr_whole_q;
		prg_whole_d = prg_whole_q;
		prg_low_d   = prg_low_q;
		prg_high_d  = prg_high_q;
		mirror_d    = mirror_q;
		unique case (kind)
			KIND_CPU_RD: begin
				if (wram_hit) begin
					res_c.handled     = 1'b1;
					res_c.to_work_ram = 1'b1;
					res_c.take_ram    = 1'b1;
				end else if (addr[15]) begin
					res_c.handled = 1'b1;
					if (!control_q[3])
						res_c.rom_offset = {prg_whole_q, addr[14:0]};
					else if (!addr[14])
						res_c.rom_offset = {prg_low_q, addr[13:0]};
					else
						res_c.rom_offset = {prg_high_q, addr[13:0]};
				end
			end
			KIND_CPU_WR: begin
				if (wram_hit) begin
					res_c.handled     = 1'b1;
					res_c.to_work_ram = 1'b1;
				end else if (addr[15]) begin
					if (din[7]) begin
						shift_d   = '0;
						count_d   = '0;
						control_d = control_q | CONTROL_PRG_FIX;
					end else if (count_q != LOADER_LAST) begin
						shift_d = load_v;
						count_d = count_q + 3'd1;
					end else begin
						// fifth bit: commit the loader to the addressed register
						shift_d = '0;
						count_d = '0;
						unique case (tgt_t'(addr[14:13]))
							TGT_CONTROL: begin
								control_d = load_v;
								mirror_d  = {1'b0, load_v[1:0]} + 3'd1;
							end
							TGT_CHR_LOW: begin
								if (control_q[4])
									chr_low_d = load_v;
								else
									chr_whole_d = load_v[4:1];
							end
							TGT_CHR_HIGH: begin
								if (control_q[4])
									chr_high_d = load_v;
							end
							TGT_PRG: begin
								priority if (!control_q[3]) begin
									prg_whole_d = load_v[3:1];
								end else if (control_q[3:2] == PRG_MODE_FIX_FIRST) begin
									prg_low_d  = '0;
									prg_high_d = load_v[3:0];
								end else begin
									prg_low_d  = load_v[3:0];
									prg_high_d = 4'(prg_count_q - 5'd1);
								end
							end
							default: ;
						endcase
					end
				end
			end
			KIND_PPU_RD: begin
				if (addr[15:13] == 3'b000) begin
					res_c.handled = 1'b1;
					if (chr_ram)
						res_c.rom_offset = {2'b00, addr};
					else if (control_q[4])
						res_c.rom_offset = {1'b0,
							(addr[12] ? chr_high_q : chr_low_q), addr[11:0]};
					else
						res_c.rom_offset = {1'b0, chr_whole_q, addr[12:0]};
				end
			end
			KIND_PPU_WR: begin
				if (addr[15:13] == 3'b000 && chr_ram) begin
					res_c.handled    = 1'b1;
					res_c.rom_offset = {2'b00, addr};
				end
			end
			default: ;
		endcase
		res_c.mirror_mode = mirror_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= PRG_COUNT_RESET;
			chr_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRG_COUNT: prg_count_q <= cfg_data[4:0];
				CFG_CHR_COUNT: chr_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// mapper register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			count_q     <= '0;
			control_q   <= CONTROL_RESET;
			chr_low_q   <= '0;
			chr_high_q  <= '0;
			chr_whole_q <= '0;
			prg_whole_q <= '0;
			prg_low_q   <= '0;
			prg_high_q  <= PRG_HIGH_RESET;
			mirror_q    <= '0;
		end else if (in_acc) begin
			shift_q     <= shift_d;
			count_q     <= count_d;
			control_q   <= control_d;
			chr_low_q   <= chr_low_d;
			chr_high_q  <= chr_high_d;
			chr_whole_q <= chr_whole_d;
			prg_whole_q <= prg_whole_d;
			prg_low_q   <= prg_low_d;
			prg_high_q  <= prg_high_d;
			mirror_q    <= mirror_d;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == RAM_LAST)
				clr_busy_q <= 1'b0;
		end
	end

	// work ram port select
	assign ram_we = clr_busy_q || (in_acc && kind == KIND_CPU_WR && wram_hit);
	assign ram_wa = clr_busy_q ? clr_idx_q : idx;
	assign ram_wd = clr_busy_q ? 8'h00 : din;

	// work ram, one write and one registered read
	always_ff @(posedge clk) begin
		if (ram_we)
			mem[ram_wa] <= ram_wd;
		if (in_acc)
			ram_rd_q <= mem[idx];
	end

	// first stage: decoded result waiting on the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			res_s1 <= res_c;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_q    <= res_s1;
			out_rd_q <= res_s1.take_ram ? ram_rd_q : 8'h00;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, out_q.mirror_mode, out_rd_q, out_q.rom_offset};
	assign m_tuser  = {out_q.to_work_ram, out_q.handled};

	// no access taken while the work ram is being cleared
	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("access accepted during work ram clear");

	// a waiting first-stage result is not dropped while the output stalls
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_v_q && !m_tready) |=> (v_s1 && $stable(res_s1)))
		else $error("first stage result lost under stall");

	// read data only comes from the work ram
	a_rd_wram: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[25:18] == 8'h00))
		else $error("read data outside work ram access");

	// unclaimed accesses and work ram accesses carry no rom offset
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (!m_tuser[0] || m_tuser[1])) |-> (m_tdata[17:0] == 18'h0))
		else $error("rom offset on unclaimed or work ram access");

endmodule
